### rtl/ssrca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrca_pkg
// Shared types and constants of the seven-state ring automaton.
// ----------------------------------------------------------------------------
package ssrca_pkg;

    localparam int NSTATES    = 7;
    localparam int RULE_DEPTH = NSTATES * NSTATES * NSTATES;
    localparam int STATE_W    = 3;
    localparam int SLOT_W     = 9;
    localparam int MODE_W     = 2;

    localparam logic [STATE_W-1:0] STATE_MAX = 3'd6;

    localparam logic [MODE_W-1:0] MODE_WR_RULE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_CELL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RD_CELL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STEP    = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic wr_rule;
        logic wr_cell;
        logic rd_cell;
        logic step_start;
        logic feed_vld;
        logic feed_rd;
        logic feed_first;
        logic feed_capture;
        logic feed_emit;
        logic out_load;
    } ssrca_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              rule_ok;
        logic              cell_ok;
        logic              out_free;
    } ssrca_status_t;

endpackage

### rtl/ssrca_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrca_ctrl
// Sequencer: decodes each request and walks the ring during a generation.
// ----------------------------------------------------------------------------
module ssrca_ctrl
    import ssrca_pkg::*;
#(
    parameter int CELLS = 64
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  ssrca_status_t                status,
    output ssrca_cmd_t                   cmd,
    output logic [$clog2(CELLS)-1:0]     step_addr
);

    localparam int AW = $clog2(CELLS);
    localparam int KW = $clog2(CELLS + 2);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_STEP   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_RESP   = 3'd5;

    localparam logic [KW-1:0] K_LAST = KW'(CELLS + 1);
    localparam logic [KW-1:0] K_ONE  = KW'(1);

    logic [2:0]    state_reg, state_next;
    logic [KW-1:0] k_reg, k_next;
    logic          drain_reg, drain_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            drain_reg <= drain_next;
        end
    end

    // feed order: last cell, then cells 0 .. CELLS-1, then the saved cell 0
    assign step_addr = (k_reg == '0) ? AW'(CELLS - 1) : AW'(k_reg - K_ONE);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        drain_next = drain_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (status.mode)
                    MODE_WR_RULE:
                    begin
                        cmd.wr_rule = status.rule_ok;
                        state_next  = ST_RESP;
                    end
                    MODE_WR_CELL:
                    begin
                        cmd.wr_cell = status.cell_ok;
                        state_next  = ST_RESP;
                    end
                    MODE_RD_CELL:
                    begin
                        cmd.rd_cell = status.cell_ok;
                        state_next  = ST_RDWAIT;
                    end
                    MODE_STEP:
                    begin
                        cmd.step_start = 1'b1;
                        k_next         = '0;
                        state_next     = ST_STEP;
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_RDWAIT:
            begin
                state_next = ST_RESP;
            end
            ST_STEP:
            begin
                cmd.feed_vld     = 1'b1;
                cmd.feed_rd      = (k_reg != K_LAST);
                cmd.feed_first   = (k_reg == K_LAST);
                cmd.feed_capture = (k_reg == K_ONE);
                cmd.feed_emit    = (k_reg > K_ONE);
                k_next           = k_reg + K_ONE;
                if (k_reg == K_LAST)
                begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last window shift, then the last rule write
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                cmd.out_load = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded while output register is blocked");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (k_reg <= K_LAST))
        else $error("step counter ran past the ring");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one is in work");

endmodule

### rtl/ssrca_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrca_datapath
// Rule and cell memories, neighbor window and result register.
// ----------------------------------------------------------------------------
module ssrca_datapath
    import ssrca_pkg::*;
#(
    parameter int CELLS = 64
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [MODE_W-1:0]            in_mode,
    input  logic [SLOT_W-1:0]            in_slot,
    input  logic [STATE_W-1:0]           in_value,
    input  ssrca_cmd_t                   cmd,
    input  logic [$clog2(CELLS)-1:0]     step_addr,
    output ssrca_status_t                status,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [STATE_W-1:0]           out_state,
    output logic                         out_done
);

    localparam int AW = $clog2(CELLS);
    localparam int RW = $clog2(RULE_DEPTH);

    logic [MODE_W-1:0]  mode_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [STATE_W-1:0] value_reg;

    logic [STATE_W-1:0] rule_mem [RULE_DEPTH];
    logic [STATE_W-1:0] cell_mem [CELLS];

    logic [STATE_W-1:0] cell_q_reg;
    logic [STATE_W-1:0] rule_q_reg;

    logic               feed_vld_reg, feed_first_reg, feed_capture_reg, feed_emit_reg;
    logic [STATE_W-1:0] win0_reg, win1_reg, first_reg;
    logic               wr_pend_reg;
    logic [AW-1:0]      wr_addr_reg;
    logic [AW-1:0]      out_cnt_reg;

    logic               m_tvalid_reg;
    logic [STATE_W-1:0] out_state_reg;
    logic               out_done_reg;

    logic               rule_ok, cell_ok;
    logic [STATE_W-1:0] feed_val;
    logic [RW-1:0]      rule_idx;
    logic [AW-1:0]      cell_rd_addr;
    logic               cell_we;
    logic [AW-1:0]      cell_wr_addr;
    logic [STATE_W-1:0] cell_wr_data;
    logic [STATE_W-1:0] res_state;
    logic               res_done;

    assign rule_ok = (32'(slot_reg) < 32'(RULE_DEPTH));
    assign cell_ok = (32'(slot_reg) < 32'(CELLS));

    assign status.mode     = mode_reg;
    assign status.rule_ok  = rule_ok;
    assign status.cell_ok  = cell_ok;
    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= in_mode;
            slot_reg  <= in_slot;
            // a written seven saturates to six
            value_reg <= (in_value > STATE_MAX) ? STATE_MAX : in_value;
        end
    end

    // window input: memory data, or the saved old cell 0 at the ring end
    assign feed_val = feed_first_reg ? first_reg : cell_q_reg;
    assign rule_idx = RW'(win1_reg)
                    + RW'(win0_reg) * RW'(NSTATES)
                    + RW'(feed_val) * RW'(NSTATES * NSTATES);

    assign cell_rd_addr = cmd.feed_rd ? step_addr : AW'(slot_reg);
    assign cell_we      = wr_pend_reg || cmd.wr_cell;
    assign cell_wr_addr = wr_pend_reg ? wr_addr_reg : AW'(slot_reg);
    assign cell_wr_data = wr_pend_reg ? rule_q_reg : value_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_rule)
        begin
            rule_mem[RW'(slot_reg)] <= value_reg;
        end
        if (feed_emit_reg)
        begin
            rule_q_reg <= rule_mem[rule_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_wr_addr] <= cell_wr_data;
        end
        if (cmd.feed_rd || cmd.rd_cell)
        begin
            cell_q_reg <= cell_mem[cell_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_vld_reg     <= 1'b0;
            feed_first_reg   <= 1'b0;
            feed_capture_reg <= 1'b0;
            feed_emit_reg    <= 1'b0;
            wr_pend_reg      <= 1'b0;
            out_cnt_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            feed_vld_reg     <= cmd.feed_vld;
            feed_first_reg   <= cmd.feed_first;
            feed_capture_reg <= cmd.feed_capture;
            feed_emit_reg    <= cmd.feed_emit;
            wr_pend_reg      <= feed_emit_reg;
            if (cmd.step_start)
            begin
                out_cnt_reg <= '0;
            end
            else if (feed_emit_reg)
            begin
                out_cnt_reg <= out_cnt_reg + AW'(1);
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed_vld_reg)
        begin
            win0_reg <= feed_val;
            win1_reg <= win0_reg;
        end
        if (feed_capture_reg)
        begin
            first_reg <= cell_q_reg;
        end
        if (feed_emit_reg)
        begin
            wr_addr_reg <= out_cnt_reg;
        end
    end

    always_comb
    begin
        res_state = '0;
        res_done  = 1'b0;
        unique case (mode_reg)
            MODE_WR_RULE: res_done = rule_ok;
            MODE_WR_CELL: res_done = cell_ok;
            MODE_RD_CELL:
            begin
                res_done  = cell_ok;
                res_state = cell_ok ? cell_q_reg : '0;
            end
            MODE_STEP:    res_done = 1'b1;
            default:      res_done = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_state_reg <= res_state;
            out_done_reg  <= res_done;
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign out_state = out_state_reg;
    assign out_done  = out_done_reg;

endmodule

### rtl/seven_state_ring_cellular_automaton_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_state_ring_cellular_automaton_top
// Ring of seven-state cells updated through a 343-entry rule table.
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one request per handshake; mode selects write rule entry,
//   write cell, read cell or advance one generation. m_* channel: one result
//   per request, holding the read state and a done flag.
//   a write request goes through the decode state to the result, a cell read
//   adds a wait for the memory read, and a generation walks the ring one cell per
//   cycle through the single cell-memory read port and the rule-table read,
//   with the new state written back in place from the registered rule read.
//   one request is in work at a time; s_tready is high only when idle, so a
//   new request is taken only once the previous result is in the output register.
//   the result sits in an output register; when the receiver stalls the
//   block still accepts and works one more request, which then waits for
//   the register to free, and input stops until the held result is taken.
//   reset clears control state only; rule entries and cells hold garbage
//   until written, with no clearing pass.
// ----------------------------------------------------------------------------
module seven_state_ring_cellular_automaton_top
    import ssrca_pkg::*;
#(
    parameter int CELLS = 64
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // mode[1:0], slot[10:2], value[13:11], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // state_out[2:0], done_res[3], zero pad
);

    localparam int AW = $clog2(CELLS);

    ssrca_cmd_t         cmd;
    ssrca_status_t      status;
    logic [AW-1:0]      step_addr;
    logic [STATE_W-1:0] out_state;
    logic               out_done;

    ssrca_ctrl #(
        .CELLS (CELLS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .status    (status),
        .cmd       (cmd),
        .step_addr (step_addr)
    );

    ssrca_datapath #(
        .CELLS (CELLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_mode   (s_tdata[1:0]),
        .in_slot   (s_tdata[10:2]),
        .in_value  (s_tdata[13:11]),
        .cmd       (cmd),
        .step_addr (step_addr),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_state (out_state),
        .out_done  (out_done)
    );

    assign m_tdata = {4'b0000, out_done, out_state};

endmodule

### verif/tb_seven_state_ring_cellular_automaton_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_state_ring_cellular_automaton_top
// Self-checking bench for the seven-state ring automaton.
// Requests go in on the s_* stream and results come back on the m_* stream.
// A behavioral copy of the rule table and the ring predicts every result.
// The rule table and ring are loaded first, so that nothing unwritten is
// ever read. Directed corner requests follow, then random traffic under
// several idle and stall mixes, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_seven_state_ring_cellular_automaton_top;
    import ssrca_pkg::*;

    localparam int CELLS       = 64;
    localparam int AW          = $clog2(CELLS);
    localparam int RW          = $clog2(RULE_DEPTH);
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [STATE_W-1:0] state_out;
        logic               done_res;
    } ca_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // mode[1:0], slot[10:2], value[13:11], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // state_out[2:0], done_res[3], zero pad

    // behavioral copy of the block's storage
    logic [STATE_W-1:0] rule_mem [RULE_DEPTH];
    logic [STATE_W-1:0] ring_mem [CELLS];

    ca_result_t pending_results [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int error_count    = 0;
    int n_generations  = 0;
    int n_reads        = 0;
    int n_writes       = 0;
    int n_ignored      = 0;
    int n_results      = 0;

    seven_state_ring_cellular_automaton_top #(
        .CELLS (CELLS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        ca_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: m_tdata %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] !== want.state_out)
                begin
                    $error("state_out mismatch: expected %0d, actual %0d",
                           want.state_out, m_tdata[2:0]);
                    error_count++;
                end
                if (m_tdata[3] !== want.done_res)
                begin
                    $error("done_res mismatch: expected %0d, actual %0d",
                           want.done_res, m_tdata[3]);
                    error_count++;
                end
            end
        end
    end

    // updates the behavioral storage and returns the result the request gives
    function automatic ca_result_t apply_request(input logic [MODE_W-1:0] mode,
                                                 input logic [SLOT_W-1:0] slot,
                                                 input logic [STATE_W-1:0] value);
        ca_result_t         res;
        logic [STATE_W-1:0] sat;
        logic [STATE_W-1:0] next_gen [CELLS];
        int                 left;
        int                 right;
        int                 idx;
        res = '0;
        sat = (value > STATE_MAX) ? STATE_MAX : value;
        case (mode)
            MODE_WR_RULE:
            begin
                if (slot < RULE_DEPTH)
                begin
                    rule_mem[RW'(slot)] = sat;
                    res.done_res        = 1'b1;
                    n_writes++;
                end
                else
                    n_ignored++;
            end
            MODE_WR_CELL:
            begin
                if (slot < CELLS)
                begin
                    ring_mem[AW'(slot)] = sat;
                    res.done_res        = 1'b1;
                    n_writes++;
                end
                else
                    n_ignored++;
            end
            MODE_RD_CELL:
            begin
                if (slot < CELLS)
                begin
                    res.state_out = ring_mem[AW'(slot)];
                    res.done_res  = 1'b1;
                    n_reads++;
                end
                else
                    n_ignored++;
            end
            default:
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    left  = (i == 0) ? CELLS - 1 : i - 1;
                    right = (i == CELLS - 1) ? 0 : i + 1;
                    idx   = ring_mem[AW'(left)] + NSTATES * ring_mem[AW'(i)]
                          + NSTATES * NSTATES * ring_mem[AW'(right)];
                    next_gen[AW'(i)] = rule_mem[RW'(idx)];
                end
                for (int i = 0; i < CELLS; i++)
                    ring_mem[AW'(i)] = next_gen[AW'(i)];
                res.done_res = 1'b1;
                n_generations++;
            end
        endcase
        return res;
    endfunction

    // valid stays high across back-to-back requests; it is lowered only for a gap
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [SLOT_W-1:0] slot,
                                input logic [STATE_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, value, slot, mode};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        pending_results.push_back(apply_request(mode, slot, value));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_tables();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < RULE_DEPTH; i++)
            send_request(MODE_WR_RULE, SLOT_W'(i), STATE_W'($urandom_range(7)));
        for (int i = 0; i < CELLS; i++)
            send_request(MODE_WR_CELL, SLOT_W'(i), STATE_W'($urandom_range(7)));
        wait_results_drained();
    endtask

    task automatic test_directed_cases();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // value seven saturates on cell 0 and rule entry 0; both ring ends are written and read
        send_request(MODE_WR_CELL, 9'd0, 3'd7);
        send_request(MODE_RD_CELL, 9'd0, 3'd0);
        send_request(MODE_WR_CELL, SLOT_W'(CELLS - 1), 3'd0);
        send_request(MODE_RD_CELL, SLOT_W'(CELLS - 1), 3'd7);
        send_request(MODE_WR_RULE, 9'd0, 3'd7);
        send_request(MODE_WR_RULE, SLOT_W'(RULE_DEPTH - 1), 3'd5);
        // out-of-range slots are ignored
        send_request(MODE_WR_RULE, SLOT_W'(RULE_DEPTH), 3'd3);
        send_request(MODE_WR_RULE, 9'h1FF, 3'd7);
        send_request(MODE_WR_CELL, SLOT_W'(CELLS), 3'd2);
        send_request(MODE_WR_CELL, 9'h1FF, 3'd7);
        send_request(MODE_RD_CELL, SLOT_W'(CELLS), 3'd0);
        send_request(MODE_RD_CELL, 9'h1FF, 3'd7);
        wait_results_drained();
        // generation steps, with junk in the unused fields
        send_request(MODE_STEP, 9'd0, 3'd0);
        send_request(MODE_RD_CELL, 9'd0, 3'd0);
        send_request(MODE_RD_CELL, SLOT_W'(CELLS - 1), 3'd0);
        send_request(MODE_STEP, 9'h1FF, 3'd7);
        send_request(MODE_RD_CELL, 9'd1, 3'd0);
        send_request(MODE_WR_CELL, 9'd1, 3'd6);
        send_request(MODE_STEP, 9'h155, 3'd5);
        send_request(MODE_RD_CELL, 9'd1, 3'd0);
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                       input int n_items);
        int                 served;
        int                 pick;
        logic [MODE_W-1:0]  mode;
        logic [SLOT_W-1:0]  slot;
        logic [STATE_W-1:0] value;
        src_idle_pct   = src_pct;
        sink_stall_pct = snk_pct;
        served         = 0;
        while (served < n_items)
        begin
            pick  = $urandom_range(99);
            value = STATE_W'($urandom_range(7));
            if (pick < 15)
            begin
                mode = MODE_WR_RULE;
                slot = ($urandom_range(9) == 0) ? SLOT_W'($urandom_range(511))
                                                : SLOT_W'($urandom_range(RULE_DEPTH - 1));
            end
            else if (pick < 75)
            begin
                mode = (pick < 40) ? MODE_WR_CELL : MODE_RD_CELL;
                slot = ($urandom_range(9) == 0) ? SLOT_W'($urandom_range(511))
                                                : SLOT_W'($urandom_range(CELLS - 1));
            end
            else
            begin
                mode = MODE_STEP;
                slot = SLOT_W'($urandom_range(511));
            end
            send_request(mode, slot, value);
            // ignored requests do not count toward the run length
            if (mode == MODE_STEP || (mode == MODE_WR_RULE && slot < RULE_DEPTH)
                || (mode != MODE_WR_RULE && slot < CELLS))
                served++;
        end
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = 300;
        for (int i = 0; i < 12; i++)
        begin
            send_request(MODE_WR_CELL, SLOT_W'($urandom_range(CELLS - 1)),
                         STATE_W'($urandom_range(7)));
            send_request(MODE_RD_CELL, SLOT_W'($urandom_range(CELLS - 1)), 3'd0);
            if (i % 4 == 0)
                send_request(MODE_STEP, 9'd0, 3'd0);
        end
        wait_results_drained();
        // one request at a time, each waiting for its result
        for (int i = 0; i < 6; i++)
        begin
            send_request(MODE_STEP, 9'd0, 3'd0);
            wait_results_drained();
            send_request(MODE_RD_CELL, SLOT_W'($urandom_range(CELLS - 1)), 3'd0);
            wait_results_drained();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_tables();
        test_directed_cases();
        test_random_traffic(0, 0, 300);
        test_random_traffic(76, 0, 300);
        test_random_traffic(0, 76, 300);
        test_random_traffic(25, 25, 300);
        test_backpressure();

        wait_results_drained();
        repeat (CELLS + 20) @(posedge clk);

        $display("covered %0d generations, %0d cell reads, %0d writes, %0d ignored requests",
                 n_generations, n_reads, n_writes, n_ignored);
        $display("%0d results checked over idle, stall and hold-off phases", n_results);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
